@@ design/tbp_pkg.sv @@
package tbp_pkg;

    // Fixed field widths of the request, the result and the registers.
    localparam int FLOW_W = 8;
    localparam int TIME_W = 32;
    localparam int CAP_W  = 16;
    localparam int RATE_W = 24;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 1'd1;

    localparam logic [CAP_W-1:0]  CAPACITY_RST = 16'd10;
    localparam logic [RATE_W-1:0] RATE_RST     = 24'd328;

    // Defaults of the top-level parameters.
    localparam int NUM_FLOWS_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Controller states: accept, multiply, add, write back.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_WB
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul;
        logic add;
        logic wb;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ design/per_flow_token_bucket_policer_core.sv @@
// Per-flow token bucket policer.
// Requests enter on the slave stream: each names a flow and carries a free-running
// tick timestamp. Every request gives exactly one result on the master stream:
// whether a token was taken, and the whole tokens left in that flow's bucket.
// Buckets are fixed point with FRAC_BITS fraction bits; a flow not yet seen
// starts full at the configured capacity.
// Capacity and refill rate are written through the configuration port; the user
// must do so only while no request is in flight: the block does not enforce it.
// A request goes through the bucket memory read, the elapsed-time multiply,
// the refill add, and the cap, decision and write back, in that order. The
// read-modify-write of the bucket memory means the block takes no new request
// until the last one is written back.
// A finished result waits in an output register; the next request is accepted
// meanwhile, and only its write back waits while the receiver stalls.
// Reset clears the seen bit of every flow and loads the register defaults.
module per_flow_token_bucket_policer_core
    import tbp_pkg::*;
#(
    parameter int NUM_FLOWS = NUM_FLOWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,  // flow_id[7:0], now_time[39:8]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_DATA_W-1:0]   o_m_axis_tdata   // allowed[0], tokens_left[16:1], zeros
);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic             allowed;
    logic [CAP_W-1:0] tokens_left;

    tbp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    tbp_datapath #(
        .NUM_FLOWS (NUM_FLOWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_flow_id     (i_s_axis_tdata[FLOW_W-1:0]),
        .i_now_time    (i_s_axis_tdata[FLOW_W+TIME_W-1:FLOW_W]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_allowed     (allowed),
        .o_tokens_left (tokens_left)
    );

    // Pack the result: decision in the lowest bit, then the token count.
    assign o_m_axis_tdata = {{(M_DATA_W - CAP_W - 1){1'b0}}, tokens_left, allowed};

endmodule

@@ design/tbp_ctrl.sv @@
module tbp_ctrl
    import tbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands. Write back waits until the output register is free.
    always_comb begin
        n_state       = r_state;
        o_s_ready     = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_WB;
            end
            ST_WB: begin
                if (i_status.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/tbp_datapath.sv @@
module tbp_datapath
    import tbp_pkg::*;
#(
    parameter int NUM_FLOWS = NUM_FLOWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [FLOW_W-1:0]     i_flow_id,
    input  logic [TIME_W-1:0]     i_now_time,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_allowed,
    output logic [CAP_W-1:0]      o_tokens_left
);

    // Only flow indices below 2^FLOW_W can occur, so deeper storage is never reached.
    localparam int FLOW_SPAN = 1 << FLOW_W;
    localparam int DEPTH     = (NUM_FLOWS < FLOW_SPAN) ? NUM_FLOWS : FLOW_SPAN;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W     = CAP_W + FRAC_BITS;
    localparam int PROD_W    = TIME_W + RATE_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRAC_BITS;

    // Configuration registers.
    logic [CAP_W-1:0]  r_cap;
    logic [RATE_W-1:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAPACITY_RST;
            r_rate <= RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY: r_cap  <= i_cfg_wdata[CAP_W-1:0];
                CFG_RATE:     r_rate <= i_cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow index reduced modulo the number of flows, as a constant table.
    logic [IDX_W-1:0] slot_lut [FLOW_SPAN];

    for (genvar g = 0; g < FLOW_SPAN; g++) begin : g_slot_lut
        localparam int SLOT = g % DEPTH;
        assign slot_lut[g] = IDX_W'(SLOT);
    end

    logic [IDX_W-1:0] in_slot;
    assign in_slot = slot_lut[i_flow_id];

    // Per-flow state: seen bits in flip-flops, level and time in memories.
    logic             r_seen [DEPTH];
    logic [LVL_W-1:0] mem_level [DEPTH];
    logic [TIME_W-1:0] mem_last [DEPTH];

    logic [IDX_W-1:0]  r_slot;
    logic [TIME_W-1:0] r_now;
    logic              r_seen_hit;
    logic [LVL_W-1:0]  r_level_rd;
    logic [TIME_W-1:0] r_last_rd;
    logic [PROD_W-1:0] r_prod;
    logic [LVL_W-1:0]  r_base;
    logic [SUM_W-1:0]  r_sum;

    logic [LVL_W-1:0]  cap_fx;
    logic [TIME_W-1:0] elapsed;
    logic [PROD_W-1:0] prod_c;
    logic [LVL_W-1:0]  capped;
    logic              ok;
    logic [LVL_W-1:0]  new_level;

    assign cap_fx = LVL_W'(r_cap) << FRAC_BITS;

    // Seen bits are cleared by reset and set when a flow is written back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_seen[i] <= 1'b0;
            end
        end else if (i_cmd.wb) begin
            r_seen[r_slot] <= 1'b1;
        end
    end

    // Memory read at request, write at write back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            mem_level[r_slot] <= new_level;
            mem_last[r_slot]  <= r_now;
        end
        if (i_cmd.capture) begin
            r_level_rd <= mem_level[in_slot];
            r_last_rd  <= mem_last[in_slot];
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot     <= in_slot;
            r_now      <= i_now_time;
            r_seen_hit <= r_seen[in_slot];
        end
    end

    // A new flow starts full with no elapsed time.
    assign elapsed = r_seen_hit ? (r_now - r_last_rd) : '0;
    assign prod_c  = PROD_W'(elapsed) * PROD_W'(r_rate);

    // Refill product, then sum with the current level.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod_c;
            r_base <= r_seen_hit ? r_level_rd : cap_fx;
        end
        if (i_cmd.add) begin
            r_sum <= SUM_W'(r_prod) + SUM_W'(r_base);
        end
    end

    // Cap at capacity and take one token if there is one.
    assign capped    = (r_sum > SUM_W'(cap_fx)) ? cap_fx : r_sum[LVL_W-1:0];
    assign ok        = (capped >= ONE);
    assign new_level = ok ? (capped - ONE) : capped;

    // Output register.
    logic             r_out_valid;
    logic             r_out_allowed;
    logic [CAP_W-1:0] r_out_tokens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wb) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out_allowed <= ok;
            r_out_tokens  <= new_level[LVL_W-1:FRAC_BITS];
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_allowed         = r_out_allowed;
    assign o_tokens_left     = r_out_tokens;

endmodule
